// File: rtl/rv64im_pkg.sv
// ----------------------------------------------------------------------------
// rv64im_pkg: shared types and codes of the RV64IM integer core
// Item kinds, result status codes, opcodes, controller and multiply/divide
// state types, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rv64im_pkg;

  localparam logic [1:0] KIND_INSTR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_SYS   = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LDWAIT  = 3'd1;
  localparam logic [2:0] ST_ECALL   = 3'd2;
  localparam logic [2:0] ST_EBREAK  = 3'd3;
  localparam logic [2:0] ST_ILLEGAL = 3'd4;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_FENCE   = 7'h0F;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_OP32    = 7'h3B;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MD   = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A7 = 5'd17;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_EXEC,
    CS_MD,
    CS_FIN
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_FIX
  } md_state_e;

  typedef struct packed {
    logic capture;
    logic md_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_md;
    logic out_free;
    logic md_done;
  } sts_t;

endpackage

// File: rtl/rv64im_integer_core.sv
// ----------------------------------------------------------------------------
// rv64im_integer_core: RV64IM integer core, one item per beat
// Executes instruction words, takes load data and syscall replies, and
// issues one result beat per item with memory request and next fetch address.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  cfg     | cfg_we_i                | cfg_wdata_i (start address, loads PC)
//  in      | in_valid_i / in_stall_o | kind_i, instr_word_i, return_value_i
//  out     | out_valid_o / out_stall_i | status_o .. syscall_code_o
//
//  An item is captured with a register file read, then executed and
//  committed. Multiply and divide hold the core through capture,
//  start, 64 one-bit steps of the iterative unit, fix-up, done handoff and
//  commit. The core takes one item at a time; a result waiting in the
//  output register does not block the next capture, only its commit.
//  Reset clears the register file valid bits, PC, pending load and halt
//  flag at once.
// ----------------------------------------------------------------------------
module rv64im_integer_core import rv64im_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] instr_word_i,
  input  logic [63:0] return_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  mem_request_o,
  output logic [63:0] mem_address_o,
  output logic [1:0]  mem_size_o,
  output logic [63:0] store_data_o,
  output logic [63:0] next_pc_o,
  output logic [63:0] syscall_code_o
);

  cmd_t cmd;
  sts_t sts;

  rv64im_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rv64im_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .kind_i         (kind_i),
    .instr_word_i   (instr_word_i),
    .return_value_i (return_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .mem_request_o  (mem_request_o),
    .mem_address_o  (mem_address_o),
    .mem_size_o     (mem_size_o),
    .store_data_o   (store_data_o),
    .next_pc_o      (next_pc_o),
    .syscall_code_o (syscall_code_o)
  );

endmodule

// File: rtl/rv64im_muldiv.sv
// ----------------------------------------------------------------------------
// rv64im_muldiv: iterative multiply/divide unit
// One bit per cycle shift-add multiply or restoring divide over 64 steps,
// then a fix-up step for sign, high-word correction and special cases.
// ----------------------------------------------------------------------------
module rv64im_muldiv import rv64im_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [2:0]  op_i,
  input  logic        word_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  md_state_e    st_q, st_d;
  logic [5:0]   cnt_q;
  logic [127:0] p_q;
  logic [63:0]  m_q, x_q, res_q;
  logic [2:0]   op_q;
  logic         word_q, negq_q, na_q, dz_q, done_q;

  logic         sgn;
  logic [63:0]  ma, mb, corr;
  logic [64:0]  sum, remt, diff;
  logic [63:0]  fix;

  always_comb begin
    sgn  = (op_i == 3'd4) || (op_i == 3'd6);
    ma   = (sgn && a_i[63]) ? (64'd0 - a_i) : a_i;
    mb   = (sgn && b_i[63]) ? (64'd0 - b_i) : b_i;
    unique case (op_i)
      3'd1:    corr = (a_i[63] ? b_i : 64'd0) + (b_i[63] ? a_i : 64'd0);
      3'd2:    corr = a_i[63] ? b_i : 64'd0;
      default: corr = 64'd0;
    endcase
    sum  = {1'b0, p_q[127:64]} + {1'b0, (p_q[0] ? m_q : 64'd0)};
    remt = p_q[127:63];
    diff = remt - {1'b0, m_q};
  end

  always_comb begin
    case (op_q)
      3'd0:         fix = p_q[63:0];
      3'd1, 3'd2,
      3'd3:         fix = p_q[127:64] - x_q;
      3'd4, 3'd5:   fix = dz_q ? {64{1'b1}} : (negq_q ? (64'd0 - p_q[63:0]) : p_q[63:0]);
      default:      fix = dz_q ? x_q : (na_q ? (64'd0 - p_q[127:64]) : p_q[127:64]);
    endcase
    if (word_q) begin
      fix = {{32{fix[31]}}, fix[31:0]};
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      MD_IDLE: if (start_i) st_d = MD_RUN;
      MD_RUN:  if (cnt_q == 6'd63) st_d = MD_FIX;
      MD_FIX:  st_d = MD_IDLE;
      default: st_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= MD_IDLE;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == MD_FIX);
      if (st_q == MD_RUN) cnt_q <= cnt_q + 6'd1;
      else                cnt_q <= 6'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == MD_IDLE && start_i) begin
      op_q   <= op_i;
      word_q <= word_i;
      negq_q <= sgn && (a_i[63] ^ b_i[63]);
      na_q   <= sgn && a_i[63];
      dz_q   <= (b_i == 64'd0);
      if (!op_i[2]) begin
        p_q <= {64'd0, b_i};
        m_q <= a_i;
        x_q <= corr;
      end else begin
        p_q <= {64'd0, ma};
        m_q <= mb;
        x_q <= a_i;
      end
    end else if (st_q == MD_RUN) begin
      if (!op_q[2]) begin
        p_q <= {sum, p_q[63:1]};
      end else if (!diff[64]) begin
        p_q <= {diff[63:0], p_q[62:0], 1'b1};
      end else begin
        p_q <= {remt[63:0], p_q[62:0], 1'b0};
      end
    end else if (st_q == MD_FIX) begin
      res_q <= fix;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == MD_IDLE) else $error("muldiv started while busy");
  a_done_after_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(st_q) == MD_FIX) else $error("muldiv done without fix-up");

endmodule

// File: rtl/rv64im_dp.sv
// ----------------------------------------------------------------------------
// rv64im_dp: datapath of the RV64IM integer core
// Register file with registered reads, item capture, decode and execute,
// architectural state commit and the output register.
// ----------------------------------------------------------------------------
module rv64im_dp import rv64im_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] instr_word_i,
  input  logic [63:0] return_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  mem_request_o,
  output logic [63:0] mem_address_o,
  output logic [1:0]  mem_size_o,
  output logic [63:0] store_data_o,
  output logic [63:0] next_pc_o,
  output logic [63:0] syscall_code_o
);

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  logic [63:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic [63:0] rd1_q, rd2_q;
  logic        v1_q, v2_q;
  logic [4:0]  ra1, ra2;

  logic [1:0]  kind_q;
  logic [31:0] w_q;
  logic [63:0] val_q;
  logic [63:0] pc_q;
  logic [8:0]  pend_q;
  logic        halted_q;

  logic        ov_q;
  logic [2:0]  st_o_q;
  logic [1:0]  req_o_q, size_o_q;
  logic [63:0] addr_o_q, sd_o_q, npc_o_q, sys_o_q;

  logic [63:0] a, b, immI, immS, immB, immJ, immU, pcp4, aluv;
  logic [6:0]  opc, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [5:0]  sh6;
  logic        ok, cond;
  logic [2:0]  st;
  logic [1:0]  req, size;
  logic [63:0] addr, sd, npc, sys, wd;
  logic        we, set_pend, clr_pend, hlt, md;
  logic [4:0]  wa;
  logic [63:0] md_a, md_b, md_res, wdata;
  logic        md_done;

  // register file: registered reads at capture, write at commit
  assign ra1 = instr_word_i[19:15];
  assign ra2 = (instr_word_i[6:0] == OPC_SYSTEM) ? REG_A7 : instr_word_i[24:20];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rd1_q  <= rf_mem[ra1];
      rd2_q  <= rf_mem[ra2];
      kind_q <= kind_i;
      w_q    <= instr_word_i;
      val_q  <= return_value_i;
    end
    if (cmd_i.finish && we && wa != 5'd0) begin
      rf_mem[wa] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        v1_q <= rf_vld_q[ra1] && (ra1 != 5'd0);
        v2_q <= rf_vld_q[ra2] && (ra2 != 5'd0);
      end
      if (cmd_i.finish && we && wa != 5'd0) begin
        rf_vld_q[wa] <= 1'b1;
      end
    end
  end

  assign a = v1_q ? rd1_q : 64'd0;
  assign b = v2_q ? rd2_q : 64'd0;

  assign opc  = w_q[6:0];
  assign rd   = w_q[11:7];
  assign f3   = w_q[14:12];
  assign f7   = w_q[31:25];
  assign sh6  = w_q[25:20];
  assign immI = {{52{w_q[31]}}, w_q[31:20]};
  assign immS = {{52{w_q[31]}}, w_q[31:25], w_q[11:7]};
  assign immB = {{51{w_q[31]}}, w_q[31], w_q[7], w_q[30:25], w_q[11:8], 1'b0};
  assign immJ = {{43{w_q[31]}}, w_q[31], w_q[19:12], w_q[20], w_q[30:21], 1'b0};
  assign immU = sx32({w_q[31:12], 12'd0});
  assign pcp4 = pc_q + 64'd4;

  // base ALU for register and immediate forms
  always_comb begin
    logic [63:0] op2;
    op2 = (opc == OPC_OP) ? b : immI;
    case (f3)
      3'd0:    aluv = a + op2;
      3'd1:    aluv = a << op2[5:0];
      3'd2:    aluv = {63'd0, $signed(a) < $signed(op2)};
      3'd3:    aluv = {63'd0, a < op2};
      3'd4:    aluv = a ^ op2;
      3'd5:    aluv = a >> op2[5:0];
      3'd6:    aluv = a | op2;
      default: aluv = a & op2;
    endcase
  end

  always_comb begin
    case (f3)
      3'd0:    cond = (a == b);
      3'd1:    cond = (a != b);
      3'd4:    cond = $signed(a) < $signed(b);
      3'd5:    cond = !($signed(a) < $signed(b));
      3'd6:    cond = a < b;
      default: cond = a >= b;
    endcase
  end

  // decode and execute of the captured item
  always_comb begin
    logic [2:0] lf3;
    lf3      = pend_q[2:0];
    ok       = 1'b1;
    st       = ST_OK;
    req      = MEM_NONE;
    addr     = 64'd0;
    size     = 2'd0;
    sd       = 64'd0;
    sys      = 64'd0;
    npc      = pc_q;
    we       = 1'b0;
    wa       = rd;
    wd       = 64'd0;
    set_pend = 1'b0;
    clr_pend = 1'b0;
    hlt      = 1'b0;
    md       = 1'b0;
    if (halted_q) begin
      st = ST_ILLEGAL;
    end else begin
      case (kind_q)
        KIND_INSTR: begin
          if (pend_q[8]) begin
            st = ST_LDWAIT;
          end else begin
            npc = pcp4;
            unique case (opc)
              OPC_LOAD: begin
                if (f3 == 3'd7) ok = 1'b0;
                st = ST_LDWAIT; req = MEM_LOAD; addr = a + immI; size = f3[1:0];
                set_pend = 1'b1;
              end
              OPC_STORE: begin
                if (f3[2]) ok = 1'b0;
                req = MEM_STORE; addr = a + immS; size = f3[1:0];
                case (f3[1:0])
                  2'd0:    sd = {56'd0, b[7:0]};
                  2'd1:    sd = {48'd0, b[15:0]};
                  2'd2:    sd = {32'd0, b[31:0]};
                  default: sd = b;
                endcase
              end
              OPC_OPIMM: begin
                we = 1'b1;
                if (f3 == 3'd1) begin
                  if (w_q[31:26] != 6'd0) ok = 1'b0;
                  wd = a << sh6;
                end else if (f3 == 3'd5) begin
                  if (w_q[31:26] == 6'h00)      wd = a >> sh6;
                  else if (w_q[31:26] == 6'h10) wd = 64'($signed(a) >>> sh6);
                  else                          ok = 1'b0;
                end else begin
                  wd = aluv;
                end
              end
              OPC_OPIMM32: begin
                we = 1'b1;
                if (f3 == 3'd0) begin
                  wd = sx32(32'(a + immI));
                end else if (f3 == 3'd1 && f7 == F7_BASE) begin
                  wd = sx32(a[31:0] << w_q[24:20]);
                end else if (f3 == 3'd5 && f7 == F7_BASE) begin
                  wd = sx32(a[31:0] >> w_q[24:20]);
                end else if (f3 == 3'd5 && f7 == F7_ALT) begin
                  wd = sx32(32'($signed(a[31:0]) >>> w_q[24:20]));
                end else begin
                  ok = 1'b0;
                end
              end
              OPC_OP: begin
                we = 1'b1;
                if (f7 == F7_MD) begin
                  md = 1'b1;
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                  wd = a - b;
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                  wd = 64'($signed(a) >>> b[5:0]);
                end else if (f7 == F7_BASE) begin
                  wd = aluv;
                end else begin
                  ok = 1'b0;
                end
              end
              OPC_OP32: begin
                we = 1'b1;
                if (f7 == F7_MD && f3 != 3'd1 && f3 != 3'd2 && f3 != 3'd3) begin
                  md = 1'b1;
                end else if (f7 == F7_ALT && f3 == 3'd0) begin
                  wd = sx32(32'(a - b));
                end else if (f7 == F7_ALT && f3 == 3'd5) begin
                  wd = sx32(32'($signed(a[31:0]) >>> b[4:0]));
                end else if (f7 == F7_BASE && f3 == 3'd0) begin
                  wd = sx32(32'(a + b));
                end else if (f7 == F7_BASE && f3 == 3'd1) begin
                  wd = sx32(a[31:0] << b[4:0]);
                end else if (f7 == F7_BASE && f3 == 3'd5) begin
                  wd = sx32(a[31:0] >> b[4:0]);
                end else begin
                  ok = 1'b0;
                end
              end
              OPC_LUI: begin
                we = 1'b1; wd = immU;
              end
              OPC_AUIPC: begin
                we = 1'b1; wd = pc_q + immU;
              end
              OPC_JAL: begin
                we = 1'b1; wd = pcp4; npc = pc_q + immJ;
              end
              OPC_JALR: begin
                if (f3 != 3'd0) ok = 1'b0;
                we = 1'b1; wd = pcp4;
                npc = (a + immI) & ~64'd1;
              end
              OPC_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) ok = 1'b0;
                if (cond) npc = pc_q + immB;
              end
              OPC_FENCE: begin
                if (f3[2:1] != 2'd0) ok = 1'b0;
              end
              OPC_SYSTEM: begin
                if (w_q == WORD_ECALL) begin
                  st = ST_ECALL; sys = b;
                end else if (w_q == WORD_EBREAK) begin
                  we = 1'b1; wa = REG_A0; wd = {64{1'b1}};
                  hlt = 1'b1; st = ST_EBREAK; npc = pc_q;
                end else begin
                  ok = 1'b0;
                end
              end
              default: ok = 1'b0;
            endcase
            if (!ok) begin
              st = ST_ILLEGAL; req = MEM_NONE; addr = 64'd0; size = 2'd0;
              sd = 64'd0; sys = 64'd0; npc = pc_q; we = 1'b0;
              set_pend = 1'b0; md = 1'b0; hlt = 1'b1;
            end
          end
        end
        KIND_LOAD: begin
          if (pend_q[8]) begin
            we = 1'b1; wa = pend_q[7:3]; clr_pend = 1'b1;
            case (lf3)
              3'd0:    wd = {{56{val_q[7]}}, val_q[7:0]};
              3'd1:    wd = {{48{val_q[15]}}, val_q[15:0]};
              3'd2:    wd = sx32(val_q[31:0]);
              3'd4:    wd = {56'd0, val_q[7:0]};
              3'd5:    wd = {48'd0, val_q[15:0]};
              3'd6:    wd = {32'd0, val_q[31:0]};
              default: wd = val_q;
            endcase
          end
        end
        KIND_SYS: begin
          we = 1'b1; wa = REG_A0; wd = val_q;
        end
        default: ;
      endcase
    end
  end

  // operand prep for word forms of multiply/divide
  always_comb begin
    md_a = a;
    md_b = b;
    if (opc == OPC_OP32) begin
      if (f3 == 3'd4 || f3 == 3'd6) begin
        md_a = sx32(a[31:0]);
        md_b = sx32(b[31:0]);
      end else if (f3 == 3'd5 || f3 == 3'd7) begin
        md_a = {32'd0, a[31:0]};
        md_b = {32'd0, b[31:0]};
      end
    end
  end

  rv64im_muldiv u_md (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.md_start),
    .op_i     (f3),
    .word_i   (opc == OPC_OP32),
    .a_i      (md_a),
    .b_i      (md_b),
    .done_o   (md_done),
    .result_o (md_res)
  );

  assign wdata = md ? md_res : wd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= 64'd0;
      pend_q   <= 9'd0;
      halted_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        pc_q <= npc;
        if (set_pend)      pend_q <= {1'b1, rd, f3};
        else if (clr_pend) pend_q <= 9'd0;
        if (hlt) halted_q <= 1'b1;
      end else if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
      if (cmd_i.finish)      ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      st_o_q   <= st;
      req_o_q  <= req;
      addr_o_q <= addr;
      size_o_q <= size;
      sd_o_q   <= sd;
      npc_o_q  <= npc;
      sys_o_q  <= sys;
    end
  end

  assign sts_o.is_md    = md;
  assign sts_o.out_free = !ov_q || !out_stall_i;
  assign sts_o.md_done  = md_done;

  assign out_valid_o    = ov_q;
  assign status_o       = st_o_q;
  assign mem_request_o  = req_o_q;
  assign mem_address_o  = addr_o_q;
  assign mem_size_o     = size_o_q;
  assign store_data_o   = sd_o_q;
  assign next_pc_o      = npc_o_q;
  assign syscall_code_o = sys_o_q;

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q) else $error("halt flag cleared");

endmodule

// File: rtl/rv64im_ctrl.sv
// ----------------------------------------------------------------------------
// rv64im_ctrl: sequencing controller of the RV64IM integer core
// Takes one beat at a time, runs execute, waits on the multiply/divide unit
// and commits once the output register can take the result.
// ----------------------------------------------------------------------------
module rv64im_ctrl import rv64im_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (st_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          st_d          = CS_EXEC;
        end
      end
      CS_EXEC: begin
        if (sts_i.is_md) begin
          cmd_o.md_start = 1'b1;
          st_d           = CS_MD;
        end else if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          st_d         = CS_IDLE;
        end
      end
      CS_MD: begin
        if (sts_i.md_done) st_d = CS_FIN;
      end
      CS_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          st_d         = CS_IDLE;
        end
      end
      default: st_d = CS_IDLE;
    endcase
  end

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free) else $error("commit into a full output register");
  a_md_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.md_start |=> st_q == CS_MD) else $error("muldiv start not followed by wait");

endmodule
